>>> rtl/pcalu_pkg.sv
// Shared types, codes and the restoring divide step for the pixel channel ALU.
// Used by pcalu_div_lane and pixel_channel_alu_core; no dependencies.
package pcalu_pkg;

    localparam int MAX_LANES = 4;
    localparam int DW        = 16;   // destination channel width
    localparam int SW        = 8;    // source byte width
    localparam int DIV_STEPS = DW;   // one quotient bit per divider stage

    // operation codes
    localparam logic [4:0] OP_NOOP     = 5'd0;
    localparam logic [4:0] OP_COPY     = 5'd1;
    localparam logic [4:0] OP_TO_SRC   = 5'd2;
    localparam logic [4:0] OP_CLAMP    = 5'd3;
    localparam logic [4:0] OP_ADD      = 5'd4;
    localparam logic [4:0] OP_SUB      = 5'd5;
    localparam logic [4:0] OP_MUL      = 5'd6;
    localparam logic [4:0] OP_DIV      = 5'd7;
    localparam logic [4:0] OP_MIN      = 5'd8;
    localparam logic [4:0] OP_DIVC     = 5'd9;
    localparam logic [4:0] OP_SET_R    = 5'd10;
    localparam logic [4:0] OP_SET_G    = 5'd11;
    localparam logic [4:0] OP_SET_B    = 5'd12;
    localparam logic [4:0] OP_SET_A    = 5'd13;
    localparam logic [4:0] OP_SET_RGB  = 5'd14;
    localparam logic [4:0] OP_SET_RGBA = 5'd15;
    localparam logic [4:0] OP_KEY_A    = 5'd16;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADOP   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_OPERATION = 2'd0;
    localparam logic [1:0] REG_CHAN_CNT  = 2'd1;
    localparam logic [1:0] REG_DIVISORS  = 2'd2;
    localparam logic [1:0] REG_FILL      = 2'd3;

    typedef struct packed {
        logic [MAX_LANES-1:0][DW-1:0] dest;
        logic [MAX_LANES-1:0][SW-1:0] src;
        logic                         last;
    } t_pix;

    // per-item side band that rides beside the divider
    typedef struct packed {
        logic [MAX_LANES-1:0][DW-1:0] res;
        logic [MAX_LANES-1:0]         use_div;
        logic [MAX_LANES-1:0]         neg;
        logic [MAX_LANES-1:0][SW-1:0] src;
        logic [1:0]                   status;
        logic                         last;
    } t_side;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] dq;    // dividend bits out at the top, quotient bits in at the bottom
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st cur, input logic [DW-1:0] dvs);
        logic [DW:0] sh;
        logic [DW:0] df;
        t_div_st     nxt;
        sh = {cur.rem, cur.dq[DW-1]};
        df = sh - {1'b0, dvs};
        if (!df[DW]) begin
            nxt.rem = df[DW-1:0];
            nxt.dq  = {cur.dq[DW-2:0], 1'b1};
        end else begin
            nxt.rem = sh[DW-1:0];
            nxt.dq  = {cur.dq[DW-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

>>> rtl/pcalu_div_lane.sv
// Pipelined unsigned 16-bit restoring divider for one channel lane.
// One quotient bit per stage; depends on pcalu_pkg.
module pcalu_div_lane (
    input  logic                               i_clk,
    input  logic [pcalu_pkg::DIV_STEPS-1:0]    i_en,
    input  logic [pcalu_pkg::DW-1:0]           i_dvd,
    input  logic [pcalu_pkg::DW-1:0]           i_dvs,
    output logic [pcalu_pkg::DW-1:0]           o_quo
);

    pcalu_pkg::t_div_st          r_st  [pcalu_pkg::DIV_STEPS];
    logic [pcalu_pkg::DW-1:0]    r_dvs [pcalu_pkg::DIV_STEPS];
    pcalu_pkg::t_div_st          w_init;

    assign w_init.rem = '0;
    assign w_init.dq  = i_dvd;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_st[0]  <= pcalu_pkg::div_step(w_init, i_dvs);
            r_dvs[0] <= i_dvs;
        end
        for (int k = 1; k < pcalu_pkg::DIV_STEPS; k++) begin
            if (i_en[k]) begin
                r_st[k]  <= pcalu_pkg::div_step(r_st[k-1], r_dvs[k-1]);
                r_dvs[k] <= r_dvs[k-1];
            end
        end
    end

    assign o_quo = r_st[pcalu_pkg::DIV_STEPS-1].dq;

endmodule

>>> rtl/pixel_channel_alu_core.sv
// Pixel channel ALU: one pixel per clock unless stalled, 19-stage pipeline (input
// register, operand stage, 16 divider stages, output register). Every stage holds
// only when the stage after it is full and stalled, so bubbles collapse and a full
// pipe streams one pixel per cycle while m_axis_tready is high. Synchronous
// active-low reset empties the pipe and loads register defaults (operation 0,
// 4 channels, divisors 1, fill 0).
module pixel_channel_alu_core #(
    parameter int LANES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // dest_lane0..3 (16b each), src_lane0..3 (8b each)
    input  logic         s_axis_tlast,   // last_pixel
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // new_dest0..3 (16b each), new_src0..3 (8b each)
    output logic [1:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast,   // last_out
    // configuration
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);

    localparam int NL   = pcalu_pkg::MAX_LANES;
    localparam int DW   = pcalu_pkg::DW;
    localparam int SW   = pcalu_pkg::SW;
    localparam int NDS  = pcalu_pkg::DIV_STEPS;
    localparam int NSTG = NDS + 3;

    // configuration registers
    logic [4:0]  r_op;
    logic [2:0]  r_cnt;
    logic [63:0] r_divs;
    logic [63:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= pcalu_pkg::OP_NOOP;
            r_cnt  <= 3'd4;
            r_divs <= 64'h0001_0001_0001_0001;
            r_fill <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcalu_pkg::REG_OPERATION: r_op   <= i_cfg_data[4:0];
                pcalu_pkg::REG_CHAN_CNT:  r_cnt  <= i_cfg_data[2:0];
                pcalu_pkg::REG_DIVISORS:  r_divs <= i_cfg_data;
                pcalu_pkg::REG_FILL:      r_fill <= i_cfg_data;
            endcase
        end
    end

    // stage valids and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];

    // stage 0: input register
    pcalu_pkg::t_pix r_in;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in.dest <= s_axis_tdata[NL*DW-1:0];
            r_in.src  <= s_axis_tdata[NL*DW +: NL*SW];
            r_in.last <= s_axis_tlast;
        end
    end

    // stage 1: operand decode and the lane results that need no divider
    pcalu_pkg::t_side       n_side;
    logic [NL-1:0][DW-1:0]  n_dvd;
    logic [NL-1:0][DW-1:0]  n_dvs;

    always_comb begin
        logic [2:0]      active;
        logic            lane_on;
        logic            bytes_op;
        logic            zero_div;
        logic            key_hit;
        logic [NL-1:0]   set;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
        logic [DW-1:0]   c;
        logic [DW-1:0]   f;
        logic [23:0]     prod;
        logic [1:0]      cidx;

        active   = (r_cnt > 3'(LANES)) ? 3'(LANES) : r_cnt;
        bytes_op = (r_op >= pcalu_pkg::OP_COPY) && (r_op <= pcalu_pkg::OP_DIVC);
        zero_div = 1'b0;
        key_hit  = (r_in.dest[0] == r_fill[15:0]) && (r_in.dest[1] == r_fill[31:16])
                && (r_in.dest[2] == r_fill[47:32]);

        set = '0;
        unique case (r_op)
            pcalu_pkg::OP_SET_R:    set = 4'b0001;
            pcalu_pkg::OP_SET_G:    set = 4'b0010;
            pcalu_pkg::OP_SET_B:    set = 4'b0100;
            pcalu_pkg::OP_SET_A:    set = 4'b1000;
            pcalu_pkg::OP_SET_RGB:  set = 4'b0111;
            pcalu_pkg::OP_SET_RGBA: set = 4'b1111;
            pcalu_pkg::OP_KEY_A:    set = {key_hit, 3'b000};
            default:                set = '0;
        endcase

        n_side.src     = r_in.src;
        n_side.last    = r_in.last;
        n_side.use_div = '0;
        n_side.neg     = '0;

        for (int i = 0; i < NL; i++) begin
            a       = r_in.dest[i];
            b       = {8'd0, r_in.src[i]};
            f       = r_fill[16*i +: 16];
            cidx    = 2'(active - 3'(i) - 3'd1);
            c       = r_divs[16*cidx +: 16];
            prod    = a * b;
            lane_on = (3'(i) < active) && (i < LANES);

            n_side.res[i] = a;
            n_dvd[i]      = a[DW-1] ? -a : a;
            n_dvs[i]      = b;

            if (bytes_op && lane_on) begin
                unique case (r_op)
                    pcalu_pkg::OP_COPY,
                    pcalu_pkg::OP_CLAMP:  n_side.res[i] = b;
                    pcalu_pkg::OP_TO_SRC: n_side.src[i] = a[SW-1:0];
                    pcalu_pkg::OP_ADD:    n_side.res[i] = a + b;
                    pcalu_pkg::OP_SUB:    n_side.res[i] = a - b;
                    pcalu_pkg::OP_MUL:    n_side.res[i] = prod[DW-1:0];
                    pcalu_pkg::OP_MIN: begin
                        n_side.res[i] = ($signed(a) < $signed(b)) ? a : b;
                    end
                    pcalu_pkg::OP_DIV: begin
                        if (b == '0) begin
                            zero_div = 1'b1;
                        end else begin
                            n_side.use_div[i] = 1'b1;
                            n_side.neg[i]     = a[DW-1];
                        end
                    end
                    pcalu_pkg::OP_DIVC: begin
                        n_dvs[i] = c[DW-1] ? -c : c;
                        if (c == '0) begin
                            zero_div = 1'b1;
                        end else begin
                            n_side.use_div[i] = 1'b1;
                            n_side.neg[i]     = a[DW-1] ^ c[DW-1];
                        end
                    end
                    default: ;
                endcase
            end
            if (set[i] && (i < LANES)) begin
                n_side.res[i] = f;
            end
        end

        if (r_op > pcalu_pkg::OP_KEY_A) begin
            n_side.status = pcalu_pkg::ST_BADOP;
        end else if (zero_div) begin
            n_side.status = pcalu_pkg::ST_DIVZERO;
        end else begin
            n_side.status = pcalu_pkg::ST_OK;
        end
    end

    // side band for stages 1 .. NDS+1, divider operands for stage 1
    pcalu_pkg::t_side       r_side [NDS+1];
    logic [NL-1:0][DW-1:0]  r_dvd;
    logic [NL-1:0][DW-1:0]  r_dvs;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_side[0] <= n_side;
            r_dvd     <= n_dvd;
            r_dvs     <= n_dvs;
        end
        for (int k = 1; k <= NDS; k++) begin
            if (w_en[k+1]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stages 2 .. NDS+1: lane dividers
    logic [NL-1:0][DW-1:0] w_quo;

    for (genvar g = 0; g < NL; g++) begin : g_lane
        if (g < LANES) begin : g_div
            pcalu_div_lane u_div (
                .i_clk (i_clk),
                .i_en  (w_en[NDS+1:2]),
                .i_dvd (r_dvd[g]),
                .i_dvs (r_dvs[g]),
                .o_quo (w_quo[g])
            );
        end else begin : g_none
            assign w_quo[g] = '0;
        end
    end

    // output register: restore quotient sign and pick the lane result
    logic [NL-1:0][DW-1:0] r_out_dest;
    logic [NL-1:0][SW-1:0] r_out_src;
    logic [1:0]            r_out_status;
    logic                  r_out_last;
    logic [NL-1:0][DW-1:0] n_out_dest;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (r_side[NDS].use_div[i]) begin
                n_out_dest[i] = r_side[NDS].neg[i] ? -w_quo[i] : w_quo[i];
            end else begin
                n_out_dest[i] = r_side[NDS].res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_out_dest   <= n_out_dest;
            r_out_src    <= r_side[NDS].src;
            r_out_status <= r_side[NDS].status;
            r_out_last   <= r_side[NDS].last;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {r_out_src, r_out_dest};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule
